// ----- rtl/kprd_pkg.sv -----
// ----------------------------------------------------------------------------
// Keypad press/release detector package
// Shared widths, reset values, register indexes and the scan result type.
// ----------------------------------------------------------------------------
package kprd_pkg;

  localparam int KeyBits  = 7;
  localparam int KeyW     = 3;
  localparam int CodeW    = 8;
  localparam int HoldW    = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int NumKeys  = 7;

  localparam logic [KeyBits-1:0] MaskReset    = '0;
  localparam logic [CodeW-1:0]   ReleaseReset = 8'd8;
  localparam logic [HoldW-1:0]   HoldReset    = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOMENTARY_MASK = 2'd0,
    CFG_RELEASE_CODE   = 2'd1,
    CFG_PRESS_HOLD     = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic            any;
    logic            momentary;
    logic [KeyW-1:0] key;
  } scan_t;

endpackage

// ----- rtl/kprd_scan.sv -----
// ----------------------------------------------------------------------------
// Keypad scan encoder
// Finds the lowest-numbered pressed key and whether it is a momentary key.
// ----------------------------------------------------------------------------
module kprd_scan (
  input  logic [kprd_pkg::KeyBits-1:0] key_levels,
  input  logic [kprd_pkg::KeyBits-1:0] momentary_key_mask,
  output kprd_pkg::scan_t              scan
);
  import kprd_pkg::*;

  localparam int ScanKeys = (NumKeys < KeyBits) ? NumKeys : KeyBits;

  always_comb begin
    scan = '0;
    for (int k = ScanKeys - 1; k >= 0; k--) begin
      if (!key_levels[k]) begin
        scan.any       = 1'b1;
        scan.momentary = momentary_key_mask[k];
        scan.key       = KeyW'(k + 1);
      end
    end
  end

endmodule

// ----- rtl/keypad_press_release_detector_core.sv -----
// ----------------------------------------------------------------------------
// Keypad press/release detector core
// One poll tick per input transfer; one result transfer per tick.
// ----------------------------------------------------------------------------
// The result of a tick is registered and presented in the cycle after its transfer.
// Throughput: one tick per cycle, set by the state update into
// the result register; a result that waits on out_ready holds off the next tick.
// Reset: state clears to idle scanning, registers return to their defaults
// (mask 0, release code 8, hold 100 ticks) and the result register empties.
module keypad_press_release_detector_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kprd_pkg::KeyBits-1:0]  key_levels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          key_valid,
  output logic [kprd_pkg::CodeW-1:0]    key_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kprd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [kprd_pkg::CfgDataW-1:0] cfg_data
);
  import kprd_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_WAIT_UP    = 3'd1,
    MODE_REPORT     = 3'd2,
    MODE_MOM_REPORT = 3'd3,
    MODE_MOM_HELD   = 3'd4,
    MODE_HOLD       = 3'd5
  } mode_t;

  mode_t              mode, mode_next;
  logic [KeyW-1:0]    pressed_key, pressed_key_next;
  logic [CodeW-1:0]   last_reported, last_reported_next;
  logic [HoldW-1:0]   hold_count, hold_count_next;
  logic [HoldW-1:0]   hold_dec;
  logic               valid_next;
  logic [CodeW-1:0]   code_next;

  logic [KeyBits-1:0] momentary_key_mask;
  logic [CodeW-1:0]   release_code;
  logic [HoldW-1:0]   press_hold_ticks;

  scan_t              scan;
  logic               in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  kprd_scan u_scan (
    .key_levels         (key_levels),
    .momentary_key_mask (momentary_key_mask),
    .scan               (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      momentary_key_mask <= MaskReset;
      release_code       <= ReleaseReset;
      press_hold_ticks   <= HoldReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MOMENTARY_MASK: momentary_key_mask <= cfg_data[KeyBits-1:0];
        CFG_RELEASE_CODE:   release_code       <= cfg_data[CodeW-1:0];
        CFG_PRESS_HOLD:     press_hold_ticks   <= cfg_data[HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_next          = mode;
    pressed_key_next   = pressed_key;
    last_reported_next = last_reported;
    hold_count_next    = hold_count;
    valid_next         = 1'b0;
    code_next          = '0;
    hold_dec           = (hold_count != '0) ? hold_count - 1'b1 : hold_count;
    case (mode)
      MODE_WAIT_UP: begin
        if (!scan.any) begin
          mode_next = MODE_REPORT;
        end
      end
      MODE_REPORT: begin
        valid_next         = 1'b1;
        last_reported_next = CodeW'(pressed_key);
        code_next          = CodeW'(pressed_key);
        mode_next          = MODE_IDLE;
      end
      MODE_MOM_REPORT: begin
        valid_next         = 1'b1;
        last_reported_next = CodeW'(pressed_key);
        code_next          = CodeW'(pressed_key);
        mode_next          = MODE_MOM_HELD;
      end
      MODE_MOM_HELD: begin
        if (!scan.any && last_reported != '0) begin
          valid_next         = 1'b1;
          last_reported_next = release_code;
          code_next          = release_code;
          mode_next          = MODE_IDLE;
        end
      end
      MODE_HOLD: begin
        hold_count_next = hold_dec;
        if (hold_dec == '0) begin
          mode_next = MODE_WAIT_UP;
        end
      end
      default: begin
        if (scan.any) begin
          pressed_key_next = scan.key;
          if (scan.momentary) begin
            mode_next = MODE_MOM_REPORT;
          end else if (press_hold_ticks == '0) begin
            mode_next = MODE_WAIT_UP;
          end else begin
            hold_count_next = press_hold_ticks;
            mode_next       = MODE_HOLD;
          end
        end else begin
          mode_next = MODE_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      pressed_key   <= '0;
      last_reported <= '0;
      hold_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        mode          <= mode_next;
        pressed_key   <= pressed_key_next;
        last_reported <= last_reported_next;
        hold_count    <= hold_count_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_valid <= valid_next;
      key_code  <= code_next;
    end
  end

  // A hold in progress always has ticks left to count.
  a_hold_nonzero: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_HOLD |-> hold_count != '0)
    else $error("hold mode entered with zero hold count");

  // Quiet results carry a zero code.
  a_quiet_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_valid |-> key_code == '0)
    else $error("nonzero key code without key event");

  // A report tick returns to idle and presents the captured key.
  a_report: assert property (@(posedge clk) disable iff (rst)
    in_fire && mode == MODE_REPORT |=>
      mode == MODE_IDLE && out_valid && key_valid &&
      key_code == CodeW'($past(pressed_key)))
    else $error("normal key report lost");

  // A momentary press report leads to the held state.
  a_mom_report: assert property (@(posedge clk) disable iff (rst)
    in_fire && mode == MODE_MOM_REPORT |=>
      mode == MODE_MOM_HELD && key_valid && last_reported != '0)
    else $error("momentary press report lost");

endmodule

// ----- verif/kprd_event_checker.sv -----
// ----------------------------------------------------------------------------
// Keypad press/release detector event checker
// Watches the tick, result and register channels of the detector core. It
// predicts the key event of every accepted tick from its own copy of the scan
// state and the registers, then compares each result transfer in order.
// ----------------------------------------------------------------------------
module kprd_event_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [kprd_pkg::KeyBits-1:0]  key_levels,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          key_valid,
  input  logic [kprd_pkg::CodeW-1:0]    key_code,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [kprd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [kprd_pkg::CfgDataW-1:0] cfg_data,
  output int                            fail_count,
  output int                            outstanding
);
  import kprd_pkg::*;

  typedef enum logic [2:0] {
    ST_SCAN       = 3'd0,
    ST_AWAIT_UP   = 3'd1,
    ST_REPORT_KEY = 3'd2,
    ST_REPORT_MOM = 3'd3,
    ST_MOM_HELD   = 3'd4,
    ST_HOLDING    = 3'd5
  } scan_mode_t;

  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
  } key_event_t;

  key_event_t         expected_events[$];
  scan_mode_t         mode;
  logic [KeyW-1:0]    held_key;
  logic [CodeW-1:0]   last_code;
  logic [HoldW-1:0]   hold_left;
  logic [KeyBits-1:0] mom_mask;
  logic [CodeW-1:0]   rel_code;
  logic [HoldW-1:0]   hold_ticks;

  function automatic logic [KeyW-1:0] first_pressed(input logic [KeyBits-1:0] lv);
    logic [KeyW-1:0] k;
    k = '0;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (!lv[i]) k = KeyW'(i + 1);
    end
    return k;
  endfunction

  task automatic poll_tick(input logic [KeyBits-1:0] lv, output key_event_t ev);
    logic [KeyW-1:0] k;
    k = first_pressed(lv);
    ev = '0;
    case (mode)
      ST_AWAIT_UP: begin
        if (k == '0) mode = ST_REPORT_KEY;
      end
      ST_REPORT_KEY: begin
        last_code = CodeW'(held_key);
        ev = '{valid: 1'b1, code: last_code};
        mode = ST_SCAN;
      end
      ST_REPORT_MOM: begin
        last_code = CodeW'(held_key);
        ev = '{valid: 1'b1, code: last_code};
        mode = ST_MOM_HELD;
      end
      ST_MOM_HELD: begin
        if (k == '0 && last_code != '0) begin
          last_code = rel_code;
          ev = '{valid: 1'b1, code: last_code};
          mode = ST_SCAN;
        end
      end
      ST_HOLDING: begin
        if (hold_left != '0) hold_left--;
        if (hold_left == '0) mode = ST_AWAIT_UP;
      end
      default: begin
        if (k != '0) begin
          held_key = k;
          if (mom_mask[k-1]) begin
            mode = ST_REPORT_MOM;
          end else if (hold_ticks == '0) begin
            mode = ST_AWAIT_UP;
          end else begin
            hold_left = hold_ticks;
            mode = ST_HOLDING;
          end
        end else begin
          mode = ST_SCAN;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    key_event_t ev;
    key_event_t want;
    if (rst) begin
      expected_events.delete();
      mode = ST_SCAN;
      held_key = '0;
      last_code = '0;
      hold_left = '0;
      mom_mask = MaskReset;
      rel_code = ReleaseReset;
      hold_ticks = HoldReset;
      fail_count = 0;
    end else begin
      // The result side is checked first so that a tick accepted at this
      // edge can never stand in for a result that had no expectation.
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: result transfer with no expectation: key_valid %0b key_code %0d",
                   $time, key_valid, key_code);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (key_valid !== want.valid) begin
            $display("%0t: key_valid expected %0b, actual %0b", $time, want.valid, key_valid);
            fail_count++;
          end
          if (key_code !== want.code) begin
            $display("%0t: key_code expected %0d, actual %0d", $time, want.code, key_code);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MOMENTARY_MASK: mom_mask = cfg_data[KeyBits-1:0];
          CFG_RELEASE_CODE:   rel_code = cfg_data[CodeW-1:0];
          CFG_PRESS_HOLD:     hold_ticks = cfg_data[HoldW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        poll_tick(key_levels, ev);
        expected_events.push_back(ev);
      end
    end
    outstanding = expected_events.size();
  end

endmodule

// ----- verif/keypad_press_release_detector_core_tb.sv -----
// ----------------------------------------------------------------------------
// Keypad press/release detector core testbench
// Drives poll ticks and register writes into the core under bursty input and
// a stalling result side. A directed run covers momentary and normal keys,
// held and released keys and a zero release code, then random press and
// release sequences run under several register settings, including a hold
// time beyond the random range. The event checker predicts and compares
// every result.
// ----------------------------------------------------------------------------
module keypad_press_release_detector_core_tb;
  import kprd_pkg::*;

  localparam logic [KeyBits-1:0] AllUp = '1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic [KeyBits-1:0]  key_levels = '1;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  cfg_index_t          cfg_index = CFG_MOMENTARY_MASK;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_ready;
  logic                out_valid;
  logic                key_valid;
  logic [CodeW-1:0]    key_code;
  logic                cfg_ready;
  int                  fail_count;
  int                  outstanding;

  int                  burst_left = 0;
  int                  ticks_sent = 0;
  int                  hold_setting = int'(HoldReset);
  int                  stall_run = 0;
  int                  stall_style = 0;
  int                  stall_phase = 0;

  keypad_press_release_detector_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_levels (key_levels),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_valid  (key_valid),
    .key_code   (key_code),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  kprd_event_checker event_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .key_levels  (key_levels),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_valid   (key_valid),
    .key_code    (key_code),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_run = $urandom_range(4, 60);
    end
    stall_run--;
    stall_phase++;
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      2: out_ready <= (stall_phase % 3 != 0);
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(input logic [KeyBits-1:0] lv);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    key_levels <= lv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_PRESS_HOLD) hold_setting = int'(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(input int mask, input int rel, input int hold);
    write_reg(CFG_MOMENTARY_MASK, CfgDataW'(mask));
    write_reg(CFG_RELEASE_CODE, CfgDataW'(rel));
    write_reg(CFG_PRESS_HOLD, CfgDataW'(hold));
  endtask

  // Key is pressed, every lower key is up and higher keys are random.
  function automatic logic [KeyBits-1:0] levels_for(input int key);
    logic [KeyBits-1:0] lv;
    lv = KeyBits'($urandom);
    lv = lv | KeyBits'((1 << (key - 1)) - 1);
    lv[key-1] = 1'b0;
    return lv;
  endfunction

  // Mostly press-then-release sequences, long enough on the release side to
  // let the hold time run out, with some noise mixed in.
  task automatic run_random(input int n);
    int stop_at;
    int key;
    int span;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_tick(KeyBits'($urandom));
      end else begin
        key = $urandom_range(1, NumKeys);
        repeat ($urandom_range(1, 4)) begin
          send_tick(levels_for(($urandom_range(0, 4) == 0) ? $urandom_range(1, NumKeys) : key));
        end
        span = $urandom_range(1, 3) + ((hold_setting <= 120) ? hold_setting : 0);
        repeat (span) send_tick(($urandom_range(0, 11) == 0) ? KeyBits'($urandom) : AllUp);
      end
    end
  endtask

  initial begin
    logic [KeyBits-1:0] directed_ticks[19];
    directed_ticks = '{7'h7F, 7'h7E, 7'h7E, 7'h7D, 7'h00, 7'h7F, 7'h7D, 7'h7D, 7'h7F,
                       7'h7F, 7'h3F, 7'h3F, 7'h7F, 7'h5F, 7'h7F, 7'h00, 7'h00, 7'h7F,
                       7'h7F};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Odd keys momentary, zero release code, zero hold time.
    set_regs('h55, 0, 0);
    foreach (directed_ticks[i]) send_tick(directed_ticks[i]);
    settle();

    set_regs('h7F, 255, 1);
    run_random(60);
    settle();

    set_regs(int'(MaskReset), int'(ReleaseReset), int'(HoldReset));
    run_random(200);
    settle();

    set_regs($urandom_range(0, 127), $urandom_range(0, 255), 0);
    run_random(60);
    settle();

    set_regs($urandom_range(0, 127), 0, $urandom_range(2, 6));
    run_random(60);
    repeat (12) send_tick(AllUp);
    settle();

    // Hold time beyond the random range: one normal press, the full hold,
    // then the release.
    set_regs(0, $urandom_range(0, 255), 130);
    send_tick(levels_for(1));
    repeat (130) send_tick(KeyBits'($urandom));
    repeat (4) send_tick(AllUp);
    settle();

    set_regs($urandom_range(0, 127), $urandom_range(0, 255), 3);
    run_random(40);
    settle();

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
